// File: design/q2r_pkg.sv
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared widths and types for the quaternion to rotation matrix core.
// ----------------------------------------------------------------------------
package q2r_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int FRAC_DIAG = SAMPLE_W - 1;
   localparam int FRAC_OFF  = SAMPLE_W - 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage
// ----------------------------------------------------------------------------

// File: design/q2r_round_sat.sv
// ----------------------------------------------------------------------------
// q2r_round_sat
// Scales one exact matrix entry back to Q1.15, rounding to nearest with ties
// away from zero, then saturates; the result is registered.
// ----------------------------------------------------------------------------
module q2r_round_sat (
   input  logic                clock,
   input  q2r_pkg::acc_type    sum_i,
   input  logic                off_diag_i,
   output q2r_pkg::sample_type entry_ff
);
   import q2r_pkg::*;

   localparam acc_type HALF_DIAG = acc_type'(1) <<< (FRAC_DIAG - 1);
   localparam acc_type HALF_OFF  = acc_type'(1) <<< (FRAC_OFF - 1);
   localparam acc_type LIM_MAX   = acc_type'(SAMPLE_MAX);
   localparam acc_type LIM_MIN   = acc_type'(SAMPLE_MIN);

   acc_type    bias;
   acc_type    biased;
   acc_type    scaled;
   sample_type entry_in;

   // negative values take one less so the arithmetic shift rounds away from zero
   always_comb begin
      bias     = off_diag_i ? HALF_OFF : HALF_DIAG;
      biased   = sum_i + bias - acc_type'({1'b0, sum_i[ACC_W-1]});
      scaled   = off_diag_i ? (biased >>> FRAC_OFF) : (biased >>> FRAC_DIAG);
      if (scaled > LIM_MAX) begin
         entry_in = SAMPLE_MAX;
      end else if (scaled < LIM_MIN) begin
         entry_in = SAMPLE_MIN;
      end else begin
         entry_in = scaled[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
// ----------------------------------------------------------------------------

// File: design/quaternion_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Converts a Q1.15 quaternion to its 3x3 direction cosine matrix, Q1.15,
// rounded and saturated.
//
//   channel   handshake        payload
//   request   start / busy     req_quat_w, req_quat_x, req_quat_y, req_quat_z
//   response  rsp_valid        rsp_rot_r0c0 .. rsp_rot_r2c2
//
// one quaternion per cycle; each result reaches the ports through the registered stages below
// stages: input register, ten 16x16 products, pair sums, diagonal differences,
// round and saturate
// busy is always low; the receiver cannot stall, so nothing ever backs up
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  q2r_pkg::sample_type req_quat_w,
   input  q2r_pkg::sample_type req_quat_x,
   input  q2r_pkg::sample_type req_quat_y,
   input  q2r_pkg::sample_type req_quat_z,
   output logic                rsp_valid,
   output q2r_pkg::sample_type rsp_rot_r0c0,
   output q2r_pkg::sample_type rsp_rot_r0c1,
   output q2r_pkg::sample_type rsp_rot_r0c2,
   output q2r_pkg::sample_type rsp_rot_r1c0,
   output q2r_pkg::sample_type rsp_rot_r1c1,
   output q2r_pkg::sample_type rsp_rot_r1c2,
   output q2r_pkg::sample_type rsp_rot_r2c0,
   output q2r_pkg::sample_type rsp_rot_r2c1,
   output q2r_pkg::sample_type rsp_rot_r2c2
);
   import q2r_pkg::*;

   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   // stage 1: input beat
   sample_type w_ff, x_ff, y_ff, z_ff;

   // stage 2: products
   prod_type ww_ff, xx_ff, yy_ff, zz_ff;
   prod_type wx_ff, wy_ff, wz_ff, xy_ff, xz_ff, yz_ff;

   // stage 3: pair sums of squares and off-diagonal sums
   acc_type wwxx_ff, yyzz_ff, wwyy_ff, xxzz_ff, wwzz_ff, xxyy_ff;
   acc_type s3_r0c1_ff, s3_r0c2_ff, s3_r1c0_ff, s3_r1c2_ff, s3_r2c0_ff, s3_r2c1_ff;

   // stage 4: exact entries
   acc_type e_ff [9];

   assign busy      = 1'b0;
   assign valid_in  = {valid_ff[3:0], start};
   assign rsp_valid = valid_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= req_quat_w;
      x_ff <= req_quat_x;
      y_ff <= req_quat_y;
      z_ff <= req_quat_z;

      ww_ff <= prod_type'(w_ff) * prod_type'(w_ff);
      xx_ff <= prod_type'(x_ff) * prod_type'(x_ff);
      yy_ff <= prod_type'(y_ff) * prod_type'(y_ff);
      zz_ff <= prod_type'(z_ff) * prod_type'(z_ff);
      wx_ff <= prod_type'(w_ff) * prod_type'(x_ff);
      wy_ff <= prod_type'(w_ff) * prod_type'(y_ff);
      wz_ff <= prod_type'(w_ff) * prod_type'(z_ff);
      xy_ff <= prod_type'(x_ff) * prod_type'(y_ff);
      xz_ff <= prod_type'(x_ff) * prod_type'(z_ff);
      yz_ff <= prod_type'(y_ff) * prod_type'(z_ff);

      wwxx_ff    <= acc_type'(ww_ff) + acc_type'(xx_ff);
      yyzz_ff    <= acc_type'(yy_ff) + acc_type'(zz_ff);
      wwyy_ff    <= acc_type'(ww_ff) + acc_type'(yy_ff);
      xxzz_ff    <= acc_type'(xx_ff) + acc_type'(zz_ff);
      wwzz_ff    <= acc_type'(ww_ff) + acc_type'(zz_ff);
      xxyy_ff    <= acc_type'(xx_ff) + acc_type'(yy_ff);
      s3_r0c1_ff <= acc_type'(xy_ff) - acc_type'(wz_ff);
      s3_r0c2_ff <= acc_type'(xz_ff) + acc_type'(wy_ff);
      s3_r1c0_ff <= acc_type'(xy_ff) + acc_type'(wz_ff);
      s3_r1c2_ff <= acc_type'(yz_ff) - acc_type'(wx_ff);
      s3_r2c0_ff <= acc_type'(xz_ff) - acc_type'(wy_ff);
      s3_r2c1_ff <= acc_type'(yz_ff) + acc_type'(wx_ff);

      e_ff[0] <= wwxx_ff - yyzz_ff;
      e_ff[1] <= s3_r0c1_ff;
      e_ff[2] <= s3_r0c2_ff;
      e_ff[3] <= s3_r1c0_ff;
      e_ff[4] <= wwyy_ff - xxzz_ff;
      e_ff[5] <= s3_r1c2_ff;
      e_ff[6] <= s3_r2c0_ff;
      e_ff[7] <= s3_r2c1_ff;
      e_ff[8] <= wwzz_ff - xxyy_ff;
   end

   // off-diagonal entries carry the factor of two in a shorter shift
   q2r_round_sat u_rs_r0c0 (.clock(clock), .sum_i(e_ff[0]), .off_diag_i(1'b0),
                            .entry_ff(rsp_rot_r0c0));
   q2r_round_sat u_rs_r0c1 (.clock(clock), .sum_i(e_ff[1]), .off_diag_i(1'b1),
                            .entry_ff(rsp_rot_r0c1));
   q2r_round_sat u_rs_r0c2 (.clock(clock), .sum_i(e_ff[2]), .off_diag_i(1'b1),
                            .entry_ff(rsp_rot_r0c2));
   q2r_round_sat u_rs_r1c0 (.clock(clock), .sum_i(e_ff[3]), .off_diag_i(1'b1),
                            .entry_ff(rsp_rot_r1c0));
   q2r_round_sat u_rs_r1c1 (.clock(clock), .sum_i(e_ff[4]), .off_diag_i(1'b0),
                            .entry_ff(rsp_rot_r1c1));
   q2r_round_sat u_rs_r1c2 (.clock(clock), .sum_i(e_ff[5]), .off_diag_i(1'b1),
                            .entry_ff(rsp_rot_r1c2));
   q2r_round_sat u_rs_r2c0 (.clock(clock), .sum_i(e_ff[6]), .off_diag_i(1'b1),
                            .entry_ff(rsp_rot_r2c0));
   q2r_round_sat u_rs_r2c1 (.clock(clock), .sum_i(e_ff[7]), .off_diag_i(1'b1),
                            .entry_ff(rsp_rot_r2c1));
   q2r_round_sat u_rs_r2c2 (.clock(clock), .sum_i(e_ff[8]), .off_diag_i(1'b0),
                            .entry_ff(rsp_rot_r2c2));

endmodule
// ----------------------------------------------------------------------------
